// ===== rtl/slcd_pkg.sv =====
// Package with the shared types, constants and CRC function of the sync/length/CRC16 deframer.
`timescale 1ns / 1ps

package slcd_pkg;

  localparam int CNT_W     = 32;
  localparam int OUT_CNT_W = 32;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 16;
  localparam int CRC_W     = 16;
  localparam int CFG_IDX_W = 8;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

  localparam logic [BYTE_W-1:0] FIRST_SYNC_RESET  = 8'd66;
  localparam logic [BYTE_W-1:0] SECOND_SYNC_RESET = 8'd76;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SYNC  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_SYNC = 8'd1;

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CRC_LO,
    PH_CRC_HI
  } slcd_phase_t;

  typedef struct packed {
    logic                 valid;
    logic [BYTE_W-1:0]    payload_byte;
    logic                 is_end;
    logic                 crc_ok;
    logic [OUT_CNT_W-1:0] frame_count;
    logic [OUT_CNT_W-1:0] crc_error_count;
  } slcd_result_t;

  // One byte of reflected CRC-16, least significant bit first.
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/slcd_parser.sv =====
// Frame parser state machine: sync hunt, length, payload, CRC check and counters.
`timescale 1ns / 1ps

module slcd_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  logic [slcd_pkg::BYTE_W-1:0]       in_byte,
  input  logic [slcd_pkg::BYTE_W-1:0]       first_sync,
  input  logic [slcd_pkg::BYTE_W-1:0]       second_sync,
  output slcd_pkg::slcd_result_t            res
);

  slcd_pkg::slcd_phase_t             phase_r, phase_nxt;
  logic [slcd_pkg::LEN_W-1:0]        bytes_left_r, bytes_left_nxt;
  logic [slcd_pkg::BYTE_W-1:0]       low_r, low_nxt;
  logic [slcd_pkg::CRC_W-1:0]        crc_r, crc_nxt;
  logic [slcd_pkg::CNT_W-1:0]        frames_r, frames_nxt;
  logic [slcd_pkg::CNT_W-1:0]        fails_r, fails_nxt;
  logic [slcd_pkg::CRC_W-1:0]        crc_fed;
  logic [slcd_pkg::CRC_W-1:0]        rx_crc;
  logic [slcd_pkg::LEN_W-1:0]        len_rx;
  logic                              crc_match;

  assign crc_fed   = slcd_pkg::crc_feed((phase_r == slcd_pkg::PH_LEN_LO) ?
                                        slcd_pkg::CRC_INIT : crc_r, in_byte);
  assign rx_crc    = {in_byte, low_r};
  assign len_rx    = {in_byte, low_r};
  assign crc_match = (rx_crc == crc_r);

  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    low_nxt        = low_r;
    crc_nxt        = crc_r;
    frames_nxt     = frames_r;
    fails_nxt      = fails_r;
    res            = '0;
    case (phase_r)
      slcd_pkg::PH_SYNC1: begin
        if (in_byte == first_sync) begin
          phase_nxt = slcd_pkg::PH_SYNC2;
        end
      end
      slcd_pkg::PH_SYNC2: begin
        phase_nxt = (in_byte == second_sync) ? slcd_pkg::PH_LEN_LO : slcd_pkg::PH_SYNC1;
      end
      slcd_pkg::PH_LEN_LO: begin
        crc_nxt   = crc_fed;
        low_nxt   = in_byte;
        phase_nxt = slcd_pkg::PH_LEN_HI;
      end
      slcd_pkg::PH_LEN_HI: begin
        crc_nxt        = crc_fed;
        bytes_left_nxt = len_rx;
        phase_nxt      = (len_rx != '0) ? slcd_pkg::PH_PAYLOAD : slcd_pkg::PH_CRC_LO;
      end
      slcd_pkg::PH_PAYLOAD: begin
        crc_nxt        = crc_fed;
        bytes_left_nxt = bytes_left_r - slcd_pkg::LEN_W'(1);
        if (bytes_left_nxt == '0) begin
          phase_nxt = slcd_pkg::PH_CRC_LO;
        end
        res.valid        = step;
        res.payload_byte = in_byte;
      end
      slcd_pkg::PH_CRC_LO: begin
        low_nxt   = in_byte;
        phase_nxt = slcd_pkg::PH_CRC_HI;
      end
      slcd_pkg::PH_CRC_HI: begin
        frames_nxt = frames_r + slcd_pkg::CNT_W'(1);
        if (!crc_match) begin
          fails_nxt = fails_r + slcd_pkg::CNT_W'(1);
        end
        phase_nxt      = slcd_pkg::PH_SYNC1;
        bytes_left_nxt = '0;
        crc_nxt        = slcd_pkg::CRC_INIT;
        res.valid      = step;
        res.is_end     = 1'b1;
        res.crc_ok     = crc_match;
      end
      default: begin
        phase_nxt = slcd_pkg::PH_SYNC1;
      end
    endcase
    res.frame_count     = slcd_pkg::OUT_CNT_W'(frames_nxt);
    res.crc_error_count = slcd_pkg::OUT_CNT_W'(fails_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= slcd_pkg::PH_SYNC1;
      bytes_left_r <= '0;
      low_r        <= '0;
      crc_r        <= slcd_pkg::CRC_INIT;
      frames_r     <= '0;
      fails_r      <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      low_r        <= low_nxt;
      crc_r        <= crc_nxt;
      frames_r     <= frames_nxt;
      fails_r      <= fails_nxt;
    end
  end

  a_end_restarts_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == slcd_pkg::PH_CRC_HI |=>
      phase_r == slcd_pkg::PH_SYNC1 && crc_r == slcd_pkg::CRC_INIT && bytes_left_r == '0)
    else $error("Parser did not return to the sync hunt after a frame end.");

  a_payload_countdown: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == slcd_pkg::PH_PAYLOAD |=>
      bytes_left_r == $past(bytes_left_r) - slcd_pkg::LEN_W'(1))
    else $error("Payload byte count did not step down by one.");

  a_frame_counted: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == slcd_pkg::PH_CRC_HI |=>
      frames_r == $past(frames_r) + slcd_pkg::CNT_W'(1))
    else $error("Frame counter missed a completed frame.");

endmodule

// ===== rtl/sync_length_crc16_deframer_unit.sv =====
// Top level of the sync/length/CRC16 deframer: stream ports, register stages, configuration.
`timescale 1ns / 1ps
// A byte transferred on the input passes through the input register and then the result
// register before it can leave as a result transfer.
// Throughput: one byte per cycle while the result register is empty or out_tready is high;
// the single-byte CRC update and parser step sit between the input and the result register.
// Reset (synchronous, rst_n low): sync hunt restarts, CRC returns to 0xFFFF, counters
// clear, sync bytes return to 'B' and 'L', both register stages empty.

module sync_length_crc16_deframer_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // in_byte
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [71:0]                        out_tdata,  // payload_byte, frame_count,
                                                         // crc_error_count
  output logic                               out_tlast,  // is_end
  output logic                               out_tuser,  // crc_ok
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [slcd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [slcd_pkg::BYTE_W-1:0]        cfg_data
);

  logic [slcd_pkg::BYTE_W-1:0] first_sync_r, second_sync_r;
  logic                        in_valid_r;
  logic [slcd_pkg::BYTE_W-1:0] in_byte_r;
  logic                        advance;
  slcd_pkg::slcd_result_t      res;
  slcd_pkg::slcd_result_t      res_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_sync_r  <= slcd_pkg::FIRST_SYNC_RESET;
      second_sync_r <= slcd_pkg::SECOND_SYNC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        slcd_pkg::REG_FIRST_SYNC:  first_sync_r  <= cfg_data;
        slcd_pkg::REG_SECOND_SYNC: second_sync_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign advance   = in_valid_r && (!res_r.valid || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  slcd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .in_byte     (in_byte_r),
    .first_sync  (first_sync_r),
    .second_sync (second_sync_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else if (advance || out_tready) begin
      res_r.valid <= advance && res.valid;
    end
    if (advance && res.valid) begin
      res_r.payload_byte    <= res.payload_byte;
      res_r.is_end          <= res.is_end;
      res_r.crc_ok          <= res.crc_ok;
      res_r.frame_count     <= res.frame_count;
      res_r.crc_error_count <= res.crc_error_count;
    end
  end

  assign out_tvalid = res_r.valid;
  assign out_tdata  = {res_r.crc_error_count, res_r.frame_count, res_r.payload_byte};
  assign out_tlast  = res_r.is_end;
  assign out_tuser  = res_r.crc_ok;

  a_payload_has_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !out_tuser)
    else $error("Payload transfer carries a CRC verdict.");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_tready)
    else $error("Input stalled while the input register is empty.");

  a_stalled_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && res_r.valid && !out_tready |=> in_valid_r && $stable(in_byte_r))
    else $error("Input byte lost while the result register was blocked.");

endmodule

// ===== verif/slcd_checker.sv =====
// CRC helpers and the checker that predicts and compares deframer results from the stream channels.
`timescale 1ns / 1ps

package slcd_tb_pkg;

  localparam logic [15:0] MODBUS_POLY = 16'hA001;
  localparam logic [15:0] MODBUS_SEED = 16'hFFFF;

  localparam logic [7:0] REG_BEYOND_LAST = 8'd2;
  localparam logic [7:0] REG_INDEX_MAX   = 8'hFF;

  function automatic logic [15:0] modbus_crc_add(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) begin
      r = r[0] ? ((r >> 1) ^ MODBUS_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

module slcd_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [7:0]                    in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [71:0]                   out_tdata,
  input  logic                          out_tlast,
  input  logic                          out_tuser,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [slcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output int unsigned                   error_count,
  output int unsigned                   pending_count
);

  import slcd_pkg::*;
  import slcd_tb_pkg::*;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        ok;
    logic [31:0] frames;
    logic [31:0] crc_errors;
  } frame_result_t;

  frame_result_t frame_results[$];

  logic [7:0]       sync_first;
  logic [7:0]       sync_second;
  slcd_phase_t      phase;
  logic [15:0]      bytes_left;
  logic [7:0]       low_hold;
  logic [15:0]      crc_acc;
  logic [CNT_W-1:0] frames_seen;
  logic [CNT_W-1:0] crc_fails;
  int unsigned      errors;

  initial begin
    errors = 0;
  end

  task automatic deframe_byte(input logic [7:0] b);
    frame_result_t r;
    logic [15:0]   rx;
    r = '0;
    case (phase)
      PH_SYNC1: begin
        if (b == sync_first) phase = PH_SYNC2;
      end
      PH_SYNC2: begin
        phase = (b == sync_second) ? PH_LEN_LO : PH_SYNC1;
      end
      PH_LEN_LO: begin
        crc_acc  = modbus_crc_add(MODBUS_SEED, b);
        low_hold = b;
        phase    = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        crc_acc    = modbus_crc_add(crc_acc, b);
        bytes_left = {b, low_hold};
        phase      = (bytes_left != 16'd0) ? PH_PAYLOAD : PH_CRC_LO;
      end
      PH_PAYLOAD: begin
        crc_acc    = modbus_crc_add(crc_acc, b);
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'd0) phase = PH_CRC_LO;
        r.data       = b;
        r.frames     = frames_seen[31:0];
        r.crc_errors = crc_fails[31:0];
        frame_results.push_back(r);
      end
      PH_CRC_LO: begin
        low_hold = b;
        phase    = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        rx          = {b, low_hold};
        r.ok        = (rx == crc_acc);
        frames_seen = frames_seen + CNT_W'(1);
        if (!r.ok) crc_fails = crc_fails + CNT_W'(1);
        phase      = PH_SYNC1;
        bytes_left = 16'd0;
        crc_acc    = MODBUS_SEED;
        r.last       = 1'b1;
        r.frames     = frames_seen[31:0];
        r.crc_errors = crc_fails[31:0];
        frame_results.push_back(r);
      end
      default: begin
        phase = PH_SYNC1;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t got;
    if (!rst_n) begin
      frame_results.delete();
      sync_first  = FIRST_SYNC_RESET;
      sync_second = SECOND_SYNC_RESET;
      phase       = PH_SYNC1;
      bytes_left  = 16'd0;
      low_hold    = 8'd0;
      crc_acc     = MODBUS_SEED;
      frames_seen = '0;
      crc_fails   = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.data       = out_tdata[7:0];
        got.frames     = out_tdata[39:8];
        got.crc_errors = out_tdata[71:40];
        got.last       = out_tlast;
        got.ok         = out_tuser;
        if (frame_results.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = frame_results.pop_front();
          check_field("payload_byte", 32'(want.data), 32'(got.data));
          check_field("is_end", 32'(want.last), 32'(got.last));
          check_field("crc_ok", 32'(want.ok), 32'(got.ok));
          check_field("frame_count", want.frames, got.frames);
          check_field("crc_error_count", want.crc_errors, got.crc_errors);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIRST_SYNC:  sync_first  = cfg_data;
          REG_SECOND_SYNC: sync_second = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) deframe_byte(in_tdata);
    end
    error_count   <= errors;
    pending_count <= frame_results.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the deframer: clock, reset, byte and frame stimulus, configuration and verdict.
`timescale 1ns / 1ps

module tb_top;

  import slcd_pkg::*;
  import slcd_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = 8'h00;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [71:0]          out_tdata;
  logic                 out_tlast;
  logic                 out_tuser;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [7:0]           cfg_data   = 8'h00;

  int unsigned error_count;
  int unsigned pending_count;
  int unsigned cycles     = 0;
  int unsigned items_sent = 0;
  bit          no_gaps    = 1'b0;
  logic [7:0]  sync_first = FIRST_SYNC_RESET;
  logic [7:0]  sync_second = SECOND_SYNC_RESET;
  logic [7:0]  frame_payload[$];

  sync_length_crc16_deframer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  slcd_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= no_gaps || ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!no_gaps && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic fill_payload(input int n);
    frame_payload.delete();
    repeat (n) frame_payload.push_back(8'($urandom));
  endtask

  task automatic send_frame(input bit bad_crc);
    logic [15:0] len;
    logic [15:0] crc;
    len = 16'(frame_payload.size());
    crc = modbus_crc_add(modbus_crc_add(MODBUS_SEED, len[7:0]), len[15:8]);
    send_byte(sync_first);
    send_byte(sync_second);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    foreach (frame_payload[i]) begin
      crc = modbus_crc_add(crc, frame_payload[i]);
      send_byte(frame_payload[i]);
    end
    if (bad_crc) crc = crc ^ 16'($urandom_range(65535, 1));
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FIRST_SYNC:  sync_first  = value;
      REG_SECOND_SYNC: sync_second = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic random_traffic(input int n);
    int unsigned target;
    int unsigned pick;
    logic [7:0]  b;
    target = items_sent + n;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        fill_payload(($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(6));
        send_frame(pick >= 70);
      end else if (pick < 90) begin
        send_byte(sync_first);
        do b = 8'($urandom); while (b == sync_second);
        send_byte(b);
      end else begin
        repeat ($urandom_range(4, 1)) begin
          do b = 8'($urandom); while (b == sync_first);
          send_byte(b);
        end
      end
    end
  endtask

  initial begin
    logic [7:0] shared_sync;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero length, payload extremes, a dropped second sync byte and a bad CRC.
    fill_payload(0);
    send_frame(1'b0);
    frame_payload.delete();
    frame_payload.push_back(8'h00);
    frame_payload.push_back(8'hFF);
    send_frame(1'b0);
    send_byte(sync_first);
    send_byte(sync_first);
    send_byte(sync_second);
    frame_payload.delete();
    frame_payload.push_back(8'hA5);
    send_frame(1'b1);
    random_traffic(85);
    settle();

    write_reg(REG_FIRST_SYNC, 8'h00);
    write_reg(REG_SECOND_SYNC, 8'hFF);
    random_traffic(85);
    settle();

    write_reg(REG_FIRST_SYNC, 8'hFF);
    write_reg(REG_SECOND_SYNC, 8'h00);
    write_reg(REG_BEYOND_LAST, 8'h5A);
    write_reg(REG_INDEX_MAX, 8'h12);
    no_gaps = 1'b1;
    random_traffic(85);
    settle();
    no_gaps = 1'b0;

    shared_sync = 8'($urandom);
    write_reg(REG_FIRST_SYNC, shared_sync);
    write_reg(REG_SECOND_SYNC, shared_sync);
    random_traffic(85);
    fill_payload(256);
    send_frame(1'b0);

    settle();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
